>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

>>> src/pptb_pkg.sv
// ---------------------------------------------------------------------------
// pptb_pkg
// Types and constants of the packet pacer token bucket.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pptb_pkg;

  localparam int unsigned TimeBitsDef = 48;
  localparam int unsigned BurstW      = 16;
  localparam int unsigned IntvW       = 24;
  localparam int unsigned TokW        = 32;
  localparam int unsigned FracW       = IntvW + BurstW;
  localparam int unsigned WholeW      = TokW + BurstW;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 24;

  localparam logic [BurstW-1:0] BurstReset    = BurstW'(5);
  localparam logic [IntvW-1:0]  IntervalReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    RegBurst    = 2'd0,
    RegInterval = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CmdUpdate = 2'd0,
    CmdSent   = 2'd1,
    CmdLoss   = 2'd2,
    CmdRefill = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv1,
    StMul1,
    StMul2,
    StDiv2,
    StCache,
    StRefill,
    StEmit
  } state_e;

endpackage

`default_nettype wire

>>> src/packet_pacer_token_bucket_core.sv
// ---------------------------------------------------------------------------
// packet_pacer_token_bucket_core
// Send pacer token bucket: one request per event, one result per request.
// Sequence: sent, loss, refill and non-computing updates go from the request
//   straight to the emit state, which loads the output register once it is free;
//   a paced update first runs two passes of a shared one-bit-per-cycle divider
//   (TIME_BITS and 40 steps), and skips the second pass when the quotient saturates.
// Throughput: one request at a time; the next is taken the cycle after the
//   result is loaded, even while that result is still stalled.
// Reset: asynchronous, tokens and cached batch load 5, no last time held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module packet_pacer_token_bucket_core #(
  parameter int unsigned TIME_BITS = pptb_pkg::TimeBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pptb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [pptb_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [TIME_BITS-1:0]          now_us_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pptb_pkg::TokW-1:0]          write_budget_o,
  output logic [pptb_pkg::TokW-1:0]          cached_batch_o,
  output logic [pptb_pkg::IntvW-1:0]         wait_us_o
);

  localparam int unsigned DW   = (TIME_BITS > pptb_pkg::FracW) ? TIME_BITS : pptb_pkg::FracW;
  localparam int unsigned CntW = $clog2(DW + 1);
  localparam int unsigned TokW = pptb_pkg::TokW;
  localparam int unsigned IntvW = pptb_pkg::IntvW;
  localparam int unsigned BurstW = pptb_pkg::BurstW;
  localparam int unsigned WholeW = pptb_pkg::WholeW;
  localparam int unsigned FracW = pptb_pkg::FracW;

  pptb_pkg::state_e state_q, state_d;

  logic [BurstW-1:0]    burst_q;
  logic [IntvW-1:0]     interval_q;
  logic [TokW-1:0]      tok_q;
  logic [TokW-1:0]      cached_q;
  logic [TokW-1:0]      budget_q;
  logic [TIME_BITS-1:0] last_q;
  logic                 last_vld_q;
  logic [DW-1:0]        dvd_q;
  logic [IntvW-1:0]     rem_q;
  logic [CntW-1:0]      cnt_q;
  logic [WholeW-1:0]    whole_q;
  logic                 out_valid_q;
  logic [TokW-1:0]      out_budget_q;
  logic [TokW-1:0]      out_cached_q;
  logic [IntvW-1:0]     out_wait_q;

  pptb_pkg::cmd_e       cmd;
  logic                 in_acc;
  logic                 out_free;
  logic                 emit_go;
  logic                 div_run;
  logic                 paced;

  logic [TIME_BITS-1:0] elapsed;
  logic [IntvW:0]       rem_sh;
  logic                 q_bit;
  logic [IntvW-1:0]     rem_nx;
  logic                 q_sat;
  logic [TokW-1:0]      q_inc;
  logic [WholeW-1:0]    whole_mul;
  logic [FracW-1:0]     frac_mul;
  logic [WholeW:0]      cache_sum;
  logic                 refill_on;
  logic [TokW:0]        tok_sum;
  logic [TokW-1:0]      tok_refill;

  assign cmd   = pptb_pkg::cmd_e'(cmd_i);
  assign paced = (interval_q != '0) && last_vld_q;

  // shared restoring divider step
  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign q_bit  = (rem_sh >= {1'b0, interval_q});
  assign rem_nx = q_bit ? IntvW'(rem_sh - {1'b0, interval_q}) : IntvW'(rem_sh);

  assign elapsed   = now_us_i - last_q;
  assign q_sat     = ((dvd_q[TIME_BITS-1:0] >> 32) != '0) || (dvd_q[TokW-1:0] == '1);
  assign q_inc     = dvd_q[TokW-1:0] + TokW'(1);
  assign whole_mul = q_inc * burst_q;
  assign frac_mul  = rem_q * burst_q;
  assign cache_sum = {1'b0, whole_q} + (WholeW+1)'(dvd_q[FracW-1:0])
                     + (WholeW+1)'(rem_q != '0);
  assign refill_on = cached_q > TokW'(burst_q);
  assign tok_sum   = {1'b0, tok_q} + {1'b0, cached_q - TokW'(burst_q)};
  assign tok_refill = tok_sum[TokW] ? '1 : tok_sum[TokW-1:0];

  always_comb begin
    in_stall_o = (state_q != pptb_pkg::StIdle);
    in_acc     = in_valid_i && !in_stall_o;
    out_free   = !out_valid_q || !out_stall_i;
    emit_go    = (state_q == pptb_pkg::StEmit) && out_free;
    div_run    = (state_q == pptb_pkg::StDiv1) || (state_q == pptb_pkg::StDiv2);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pptb_pkg::StIdle: begin
        if (in_acc) begin
          if (cmd == pptb_pkg::CmdUpdate && paced) state_d = pptb_pkg::StDiv1;
          else                                     state_d = pptb_pkg::StEmit;
        end
      end
      pptb_pkg::StDiv1: begin
        if (cnt_q == CntW'(1)) state_d = pptb_pkg::StMul1;
      end
      pptb_pkg::StMul1: begin
        state_d = q_sat ? pptb_pkg::StRefill : pptb_pkg::StMul2;
      end
      pptb_pkg::StMul2: state_d = pptb_pkg::StDiv2;
      pptb_pkg::StDiv2: begin
        if (cnt_q == CntW'(1)) state_d = pptb_pkg::StCache;
      end
      pptb_pkg::StCache:  state_d = pptb_pkg::StRefill;
      pptb_pkg::StRefill: state_d = pptb_pkg::StEmit;
      pptb_pkg::StEmit: begin
        if (out_free) state_d = pptb_pkg::StIdle;
      end
      default: state_d = pptb_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pptb_pkg::StIdle;
      burst_q     <= pptb_pkg::BurstReset;
      interval_q  <= pptb_pkg::IntervalReset;
      tok_q       <= TokW'(pptb_pkg::BurstReset);
      cached_q    <= TokW'(pptb_pkg::BurstReset);
      last_q      <= '0;
      last_vld_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (pptb_pkg::cfg_reg_e'(cfg_index_i))
          pptb_pkg::RegBurst:    burst_q    <= cfg_wdata_i[BurstW-1:0];
          pptb_pkg::RegInterval: interval_q <= cfg_wdata_i[IntvW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (cmd)
          pptb_pkg::CmdUpdate: begin
            last_q     <= now_us_i;
            last_vld_q <= 1'b1;
            cnt_q      <= CntW'(TIME_BITS);
          end
          pptb_pkg::CmdSent: begin
            if (tok_q != '0) tok_q <= tok_q - TokW'(1);
          end
          pptb_pkg::CmdLoss: begin
            tok_q      <= '0;
            last_vld_q <= 1'b0;
          end
          pptb_pkg::CmdRefill: begin
            tok_q      <= TokW'(burst_q);
            last_vld_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (div_run) cnt_q <= cnt_q - CntW'(1);
      if (state_q == pptb_pkg::StMul2) cnt_q <= CntW'(FracW);
      if (state_q == pptb_pkg::StMul1 && q_sat) begin
        cached_q <= (burst_q != '0) ? '1 : '0;
      end
      if (state_q == pptb_pkg::StCache) begin
        cached_q <= (cache_sum > (WholeW+1)'({TokW{1'b1}})) ? '1 : cache_sum[TokW-1:0];
      end
      if (state_q == pptb_pkg::StRefill && refill_on) tok_q <= tok_refill;
      if (emit_go)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      unique case (cmd)
        pptb_pkg::CmdUpdate: begin
          if (interval_q == '0)  budget_q <= TokW'(burst_q);
          else                   budget_q <= tok_q;
          dvd_q <= DW'(elapsed) << (DW - TIME_BITS);
          rem_q <= '0;
        end
        pptb_pkg::CmdSent:   budget_q <= (tok_q != '0) ? tok_q - TokW'(1) : '0;
        pptb_pkg::CmdLoss:   budget_q <= '0;
        pptb_pkg::CmdRefill: budget_q <= TokW'(burst_q);
        default: ;
      endcase
    end
    if (div_run) begin
      dvd_q <= {dvd_q[DW-2:0], q_bit};
      rem_q <= rem_nx;
    end
    if (state_q == pptb_pkg::StMul1) whole_q <= whole_mul;
    if (state_q == pptb_pkg::StMul2) begin
      dvd_q <= DW'(frac_mul) << (DW - FracW);
      rem_q <= '0;
    end
    if (state_q == pptb_pkg::StRefill) budget_q <= refill_on ? tok_refill : tok_q;
    if (emit_go) begin
      out_budget_q <= budget_q;
      out_cached_q <= cached_q;
      out_wait_q   <= (tok_q != '0) ? '0 : interval_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_budget_o = out_budget_q;
  assign cached_batch_o = out_cached_q;
  assign wait_us_o      = out_wait_q;

  `ASSERT_AR(a_rem_below_div, clk_i, rst_ni, div_run |-> (rem_q < interval_q), "divider remainder out of range")
  `ASSERT_AR(a_load_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == pptb_pkg::StEmit), "result loaded outside emit")
  `ASSERT_AR(a_loss_clears, clk_i, rst_ni, (in_acc && cmd == pptb_pkg::CmdLoss) |=> (tok_q == '0 && !last_vld_q), "loss did not clear bucket")

endmodule

`default_nettype wire
